/* src/assert_macros.svh */
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define MSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/msp_pkg.sv */
// shared constants and types of the motor speed pid block
`timescale 1ns / 1ps

package msp_pkg;

  localparam int SPEED_BITS     = 16;
  localparam int GAIN_FRAC_BITS = 8;
  localparam int GAIN_W         = 16;
  localparam int DUTY_W         = 8;
  localparam int DUTY_MAX       = 255;

  // error and speed change need a sign bit and one more bit of range
  localparam int ERR_W   = SPEED_BITS + 2;
  localparam int PROD_W  = GAIN_W + ERR_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int INTEG_W = DUTY_W + GAIN_FRAC_BITS;

  localparam logic [INTEG_W-1:0] SUM_MAX = INTEG_W'(DUTY_MAX * (1 << GAIN_FRAC_BITS));

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int ADDR_W     = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_PROP  = 2'd0,
    REG_INTEG = 2'd1,
    REG_DERIV = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic                    restart;
    logic                    direction;
    logic signed [ERR_W-1:0] error;
    logic signed [ERR_W-1:0] dspeed;
  } msp_item_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
  } msp_gains_t;

endpackage

/* src/motor_speed_pid.sv */
// Motor speed PID with derivative on measurement: one sample in, one direction/duty
// result out per transfer. Sustained rate is one sample per clock cycle while out_stall is
// low, set by the single-cycle integral update in the back end; a sample goes from the
// queue entry, written at the transfer edge, to the product register and then the result
// register. A two-entry
// queue separates the front end from the back end, so input transfers continue while a
// result is stalled until the queue fills. Gains are written over the APB port at byte
// addresses 0 (proportional), 4 (integral) and 8 (derivative); any gain write clears the
// integral sum and the last speed, and gains may only be written while the block is idle.
`timescale 1ns / 1ps

module motor_speed_pid (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // sample channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [msp_pkg::SPEED_BITS-1:0] in_speed_command,
  input  logic [msp_pkg::SPEED_BITS-1:0]        in_measured_speed,
  input  logic                                  in_restart,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_direction,
  output logic [msp_pkg::DUTY_W-1:0]            out_duty,
  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [msp_pkg::ADDR_W-1:0]            paddr,
  input  logic [msp_pkg::CFG_DATA_W-1:0]        pwdata,
  output logic [msp_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                  pready
);
  import msp_pkg::*;

  msp_gains_t gains_r, gains_nxt;
  logic       cfg_wr;
  logic       cfg_clear;
  reg_idx_t   cfg_idx;
  logic       in_push;
  logic       q_full;
  logic       q_not_empty;
  logic       q_pop;
  msp_item_t  front_item;
  msp_item_t  q_head;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  // gain register writes; a valid index also restarts the loop
  always_comb begin
    gains_nxt = gains_r;
    cfg_clear = 1'b0;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_PROP: begin
          gains_nxt.kp = pwdata[GAIN_W-1:0];
          cfg_clear    = 1'b1;
        end
        REG_INTEG: begin
          gains_nxt.ki = pwdata[GAIN_W-1:0];
          cfg_clear    = 1'b1;
        end
        REG_DERIV: begin
          gains_nxt.kd = pwdata[GAIN_W-1:0];
          cfg_clear    = 1'b1;
        end
        default: begin
          cfg_clear = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r <= '0;
    end else begin
      gains_r <= gains_nxt;
    end
  end

  // register read back, sign extended
  always_comb begin
    case (cfg_idx)
      REG_PROP:  prdata = {{(CFG_DATA_W - GAIN_W){gains_r.kp[GAIN_W-1]}}, gains_r.kp};
      REG_INTEG: prdata = {{(CFG_DATA_W - GAIN_W){gains_r.ki[GAIN_W-1]}}, gains_r.ki};
      REG_DERIV: prdata = {{(CFG_DATA_W - GAIN_W){gains_r.kd[GAIN_W-1]}}, gains_r.kd};
      default:   prdata = '0;
    endcase
  end

  // input transfer goes straight into the queue
  assign in_stall = q_full;
  assign in_push  = in_valid && !q_full;

  msp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (in_push),
    .cfg_clear      (cfg_clear),
    .speed_command  (in_speed_command),
    .measured_speed (in_measured_speed),
    .restart        (in_restart),
    .item           (front_item)
  );

  msp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_item (front_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  msp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_clear     (cfg_clear),
    .gains         (gains_r),
    .q_valid       (q_not_empty),
    .q_item        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_direction (out_direction),
    .out_duty      (out_duty)
  );

endmodule

/* src/msp_front.sv */
// front end: takes samples, forms setpoint, error and speed change
`timescale 1ns / 1ps

module msp_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  logic                            cfg_clear,
  input  logic signed [msp_pkg::SPEED_BITS-1:0] speed_command,
  input  logic [msp_pkg::SPEED_BITS-1:0]  measured_speed,
  input  logic                            restart,
  output msp_pkg::msp_item_t              item
);
  import msp_pkg::*;

  logic [SPEED_BITS-1:0] prev_speed_r;
  logic [SPEED_BITS-1:0] prev_speed_nxt;
  logic [SPEED_BITS-1:0] mag;
  logic [SPEED_BITS-1:0] setpoint;

  // command magnitude, most negative value saturates
  always_comb begin
    mag = speed_command[SPEED_BITS-1] ? (~speed_command + 1'b1) : speed_command;
    setpoint = mag[SPEED_BITS-1] ? {1'b0, {(SPEED_BITS-1){1'b1}}} : mag;
  end

  // classified item handed to the queue
  always_comb begin
    item.restart   = restart;
    item.direction = ~speed_command[SPEED_BITS-1];
    item.error     = $signed({2'b00, setpoint}) - $signed({2'b00, measured_speed});
    item.dspeed    = $signed({2'b00, measured_speed}) - $signed({2'b00, prev_speed_r});
  end

  // last measured speed, cleared by restart or a gain write
  always_comb begin
    prev_speed_nxt = prev_speed_r;
    if (cfg_clear) begin
      prev_speed_nxt = '0;
    end else if (push) begin
      prev_speed_nxt = restart ? '0 : measured_speed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_speed_r <= '0;
    end else begin
      prev_speed_r <= prev_speed_nxt;
    end
  end

endmodule

/* src/msp_queue.sv */
// short fifo between front and back
`timescale 1ns / 1ps
`include "assert_macros.svh"

module msp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  msp_pkg::msp_item_t push_item,
  input  logic               pop,
  output logic               full,
  output logic               not_empty,
  output msp_pkg::msp_item_t head
);
  import msp_pkg::*;

  msp_item_t           entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                do_push;
  logic                do_pop;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = entry_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  `MSP_ASSERT_NOW(a_count_bound, 1'b1, count_r <= QCNT_W'(QUEUE_DEPTH), "queue count over depth")
  `MSP_ASSERT_NEXT(a_count_grow, do_push && !do_pop, count_r == $past(count_r) + 1'b1, "queue count did not grow on push")

endmodule

/* src/msp_back.sv */
// back end: gain products, integral update and duty output register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module msp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_clear,
  input  msp_pkg::msp_gains_t           gains,
  input  logic                          q_valid,
  input  msp_pkg::msp_item_t            q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_direction,
  output logic [msp_pkg::DUTY_W-1:0]    out_duty
);
  import msp_pkg::*;

  // product stage
  logic                     prod_valid_r, prod_valid_nxt;
  logic                     prod_restart_r;
  logic                     prod_dir_r;
  logic signed [PROD_W-1:0] kp_err_r;
  logic signed [PROD_W-1:0] ki_err_r;
  logic signed [PROD_W-1:0] kd_d_r;

  // integral and output stage
  logic [INTEG_W-1:0]       integ_r, integ_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_dir_r;
  logic [DUTY_W-1:0]        out_duty_r;
  logic [DUTY_W-1:0]        duty_nxt;

  logic                     out_free;
  logic                     prod_free;
  logic                     prod_move;
  logic signed [ACC_W-1:0]  sum_raw;
  logic signed [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]         acc_int;

  assign out_free  = !out_valid_r || !out_stall;
  assign prod_free = !prod_valid_r || out_free;
  assign q_pop     = q_valid && prod_free;
  assign prod_move = prod_valid_r && out_free;

  assign out_valid     = out_valid_r;
  assign out_direction = out_dir_r;
  assign out_duty      = out_duty_r;

  // stage valid flags
  always_comb begin
    prod_valid_nxt = prod_free ? q_valid : prod_valid_r;
    out_valid_nxt  = out_free ? prod_valid_r : out_valid_r;
  end

  // three gain products, registered
  always_ff @(posedge clk) begin
    if (q_pop) begin
      prod_restart_r <= q_item.restart;
      prod_dir_r     <= q_item.direction;
      kp_err_r       <= q_item.error * gains.kp;
      ki_err_r       <= q_item.error * gains.ki;
      kd_d_r         <= q_item.dspeed * gains.kd;
    end
  end

  // integral update with clamp, then the pid sum
  always_comb begin
    sum_raw = $signed({{(ACC_W - INTEG_W){1'b0}}, integ_r}) + ACC_W'(ki_err_r);
    if (sum_raw < 0) begin
      integ_nxt = '0;
    end else if (sum_raw > $signed({{(ACC_W - INTEG_W){1'b0}}, SUM_MAX})) begin
      integ_nxt = SUM_MAX;
    end else begin
      integ_nxt = sum_raw[INTEG_W-1:0];
    end
    acc = ACC_W'(kp_err_r) + $signed({{(ACC_W - INTEG_W){1'b0}}, integ_nxt})
          - ACC_W'(kd_d_r);
    acc_int = acc >>> GAIN_FRAC_BITS;
    if (acc[ACC_W-1] || acc == '0) begin
      duty_nxt = '0;
    end else if (acc_int[ACC_W-1:DUTY_W] != '0) begin
      duty_nxt = DUTY_W'(DUTY_MAX);
    end else begin
      duty_nxt = acc_int[DUTY_W-1:0];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      integ_r      <= '0;
    end else begin
      prod_valid_r <= prod_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_clear) begin
        integ_r <= '0;
      end else if (prod_move) begin
        integ_r <= prod_restart_r ? '0 : integ_nxt;
      end
    end
  end

  // result register, held while stalled
  always_ff @(posedge clk) begin
    if (prod_move) begin
      out_dir_r  <= prod_restart_r ? 1'b1 : prod_dir_r;
      out_duty_r <= prod_restart_r ? '0 : duty_nxt;
    end
  end

  `MSP_ASSERT_NOW(a_integ_max, 1'b1, integ_r <= SUM_MAX, "integral above clamp")
  `MSP_ASSERT_NEXT(a_restart_out, prod_move && prod_restart_r, out_valid_r && out_dir_r && out_duty_r == '0, "restart result not zero duty")

endmodule

/* sim/tb_motor_speed_pid.sv */
// self-checking testbench for the motor speed pid block: directed and random samples
`timescale 1ns / 1ps

module tb_motor_speed_pid;
  import msp_pkg::*;

  localparam int RESULT_LATENCY = 3;
  localparam int QUIET_LIMIT    = 2000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_SAMPLES  = 144;
  localparam logic [ADDR_W-1:0] ADDR_NO_REG = 4'd12;
  localparam longint SUM_LIMIT  = longint'(DUTY_MAX) << GAIN_FRAC_BITS;

  typedef struct {
    logic              direction;
    logic [DUTY_W-1:0] duty;
  } pid_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic signed [SPEED_BITS-1:0] in_speed_command = '0;
  logic [SPEED_BITS-1:0]        in_measured_speed = '0;
  logic                         in_restart = 1'b0;

  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         out_direction;
  logic [DUTY_W-1:0]            out_duty;

  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [ADDR_W-1:0]            paddr = '0;
  logic [CFG_DATA_W-1:0]        pwdata = '0;
  logic [CFG_DATA_W-1:0]        prdata;
  logic                         pready;

  // transfer flags, settled at the falling edge for the next rising edge
  logic in_take = 1'b0;
  logic out_take = 1'b0;
  logic cfg_take = 1'b0;

  // loop state of the predictor
  logic signed [GAIN_W-1:0] kp_q = '0;
  logic signed [GAIN_W-1:0] ki_q = '0;
  logic signed [GAIN_W-1:0] kd_q = '0;
  longint                   integ_acc = 0;
  logic [SPEED_BITS-1:0]    last_speed = '0;

  pid_result_t pending_results[$];
  int mismatch_count = 0;
  int quiet_cycles = 0;
  bit idle_off = 1'b0;
  int stall_left = 0;
  int stall_roll;

  // plant-like trajectory for well-formed random samples
  int track_target = 0;
  int track_speed = 0;

  motor_speed_pid DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_speed_command  (in_speed_command),
    .in_measured_speed (in_measured_speed),
    .in_restart        (in_restart),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_direction     (out_direction),
    .out_duty          (out_duty),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #1 clk = ~clk;

  // one pid step on the predictor state
  function automatic pid_result_t pid_loop_step(logic signed [SPEED_BITS-1:0] cmd,
                                                logic [SPEED_BITS-1:0] spd, logic rs);
    pid_result_t res;
    longint mag_max;
    longint setpoint;
    longint err;
    longint dspd;
    longint acc;
    longint d;
    mag_max = (longint'(1) << (SPEED_BITS - 1)) - 1;
    res.direction = 1'b1;
    res.duty = '0;
    if (rs) begin
      integ_acc = 0;
      last_speed = '0;
      return res;
    end
    setpoint = (cmd < 0) ? -longint'(cmd) : longint'(cmd);
    if (setpoint > mag_max) setpoint = mag_max;
    err = setpoint - longint'({1'b0, spd});
    dspd = longint'({1'b0, spd}) - longint'({1'b0, last_speed});
    last_speed = spd;
    integ_acc = integ_acc + longint'(ki_q) * err;
    if (integ_acc < 0) integ_acc = 0;
    if (integ_acc > SUM_LIMIT) integ_acc = SUM_LIMIT;
    acc = longint'(kp_q) * err + integ_acc - longint'(kd_q) * dspd;
    if (acc > 0) begin
      d = acc >>> GAIN_FRAC_BITS;
      if (d > DUTY_MAX) d = DUTY_MAX;
      res.duty = d[DUTY_W-1:0];
    end
    res.direction = (cmd >= 0);
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (idle_off) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 50) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // handshake flags and result checking, away from the active edge
  always @(negedge clk) begin
    in_take  = rst_n && in_valid && !in_stall;
    cfg_take = rst_n && psel && penable && pwrite && pready;
    out_take = rst_n && out_valid && !out_stall;
    if (rst_n && $isunknown(out_valid)) report_mismatch("out_valid is unknown");
    if (out_take) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result direction %b duty %0d",
                                  out_direction, out_duty));
      end else begin
        pid_result_t want;
        want = pending_results.pop_front();
        if (out_direction !== want.direction)
          report_mismatch($sformatf("direction got %b expected %b",
                                    out_direction, want.direction));
        if (out_duty !== want.duty)
          report_mismatch($sformatf("duty got %0d expected %0d", out_duty, want.duty));
      end
    end
  end

  // receiver stalls: mostly short bursts, a few long ones
  always @(posedge clk) begin
    if (!rst_n || idle_off) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      stall_roll = $urandom_range(99);
      if (stall_roll < 20) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(2, 0);
      end else if (stall_roll < 23) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(30, 8);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_take || out_take || cfg_take) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // one sample transfer, with the predicted result queued on acceptance
  task automatic send_sample(logic signed [SPEED_BITS-1:0] cmd,
                             logic [SPEED_BITS-1:0] spd, logic rs);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_speed_command <= cmd;
    in_measured_speed <= spd;
    in_restart <= rs;
    @(posedge clk);
    while (!in_take) @(posedge clk);
    pending_results.push_back(pid_loop_step(cmd, spd, rs));
  endtask

  // sender pause until every result is back and the pipeline is empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!cfg_take) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // gain write; any gain write restarts the loop
  task automatic write_gain(reg_idx_t idx, logic signed [GAIN_W-1:0] g);
    apb_write({idx, 2'b00}, {{(CFG_DATA_W - GAIN_W){g[GAIN_W-1]}}, g});
    case (idx)
      REG_PROP:  kp_q = g;
      REG_INTEG: ki_q = g;
      REG_DERIV: kd_q = g;
      default: ;
    endcase
    integ_acc = 0;
    last_speed = '0;
  endtask

  task automatic set_gains(logic signed [GAIN_W-1:0] kp, logic signed [GAIN_W-1:0] ki,
                           logic signed [GAIN_W-1:0] kd);
    wait_idle();
    write_gain(REG_PROP, kp);
    write_gain(REG_INTEG, ki);
    write_gain(REG_DERIV, kd);
  endtask

  // zero gains after reset: duty stays 0, direction follows the command sign
  task automatic test_zero_gains();
    send_sample(16'sd0, 16'd0, 1'b0);
    send_sample(-16'sd32768, 16'hffff, 1'b0);
    send_sample(16'sd32767, 16'd0, 1'b0);
  endtask

  // proportional term alone, including the most negative command
  task automatic test_proportional();
    set_gains(16'sd256, 16'sd0, 16'sd0);
    send_sample(16'sd100, 16'd0, 1'b0);
    send_sample(-16'sd32768, 16'd0, 1'b0);
    send_sample(16'sd500, 16'd600, 1'b0);
    send_sample(16'sd1, 16'd0, 1'b0);
  endtask

  // integral sum saturating high, then clamped at zero
  task automatic test_integral_clamp();
    set_gains(16'sd0, 16'sd32767, 16'sd0);
    send_sample(16'sd32767, 16'd0, 1'b0);
    send_sample(16'sd32767, 16'd0, 1'b0);
    send_sample(16'sd0, 16'hffff, 1'b0);
    send_sample(16'sd10, 16'd0, 1'b0);
  endtask

  // derivative on measured speed, both directions of change
  task automatic test_derivative();
    set_gains(16'sd0, 16'sd0, -16'sd256);
    send_sample(16'sd0, 16'd1000, 1'b0);
    send_sample(16'sd0, 16'd1000, 1'b0);
    send_sample(16'sd0, 16'd0, 1'b0);
    send_sample(16'sd0, 16'hffff, 1'b0);
  endtask

  // restart mid-stream clears the loop and forces duty 0
  task automatic test_restart();
    set_gains(16'sd0, 16'sd256, 16'sd0);
    send_sample(16'sd200, 16'd0, 1'b0);
    send_sample(-16'sd200, 16'hffff, 1'b1);
    send_sample(16'sd200, 16'd0, 1'b0);
  endtask

  // a gain write clears the integral, an unmapped write does not
  task automatic test_config_clearing();
    send_sample(16'sd300, 16'd0, 1'b0);
    wait_idle();
    write_gain(REG_PROP, 16'sd0);
    send_sample(16'sd0, 16'd0, 1'b0);
    send_sample(16'sd300, 16'd0, 1'b0);
    wait_idle();
    apb_write(ADDR_NO_REG, $urandom);
    send_sample(16'sd0, 16'd0, 1'b0);
  endtask

  // gains at their extremes
  task automatic test_gain_extremes();
    set_gains(-16'sd32768, 16'sd32767, 16'sd32767);
    send_sample(16'sd32767, 16'd0, 1'b0);
    send_sample(-16'sd1, 16'hffff, 1'b0);
    set_gains(16'sd32767, -16'sd32768, -16'sd32768);
    send_sample(16'sd32767, 16'hffff, 1'b0);
  endtask

  function automatic logic signed [GAIN_W-1:0] pick_extreme_gain();
    case ($urandom_range(4))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3: return 16'sd256;
      default: return -16'sd256;
    endcase
  endfunction

  // one random sample: mostly a tracking trajectory, some noise and restarts
  task automatic random_sample();
    int r;
    int mag;
    r = $urandom_range(99);
    if (r < 7) begin
      send_sample(SPEED_BITS'($urandom), SPEED_BITS'($urandom), 1'b1);
    end else if (r < 30) begin
      send_sample(SPEED_BITS'($urandom), SPEED_BITS'($urandom), 1'b0);
    end else begin
      if ($urandom_range(19) == 0) begin
        case ($urandom_range(9))
          0: track_target = 32767;
          1: track_target = -32768;
          default: track_target = $urandom_range(3000) * ($urandom_range(1) ? 1 : -1);
        endcase
      end
      mag = (track_target < 0) ? -track_target : track_target;
      if (mag > 32767) mag = 32767;
      track_speed = track_speed + (mag - track_speed) / 8 + int'($urandom_range(400)) - 200;
      if (track_speed < 0) track_speed = 0;
      if (track_speed > 65535) track_speed = 65535;
      send_sample(track_target[SPEED_BITS-1:0], track_speed[SPEED_BITS-1:0], 1'b0);
    end
  endtask

  // random phases over several gain settings, idling patterns and one drain pause
  task automatic test_random_phases();
    int mode;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      mode = p % 3;
      wait_idle();
      idle_off = (p == 2 || p == 5);
      case (mode)
        0: set_gains(GAIN_W'($urandom_range(1536) - 768), GAIN_W'($urandom_range(192) - 96),
                     GAIN_W'($urandom_range(512) - 256));
        1: set_gains(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom));
        default: set_gains(pick_extreme_gain(), pick_extreme_gain(), pick_extreme_gain());
      endcase
      if ($urandom_range(1)) apb_write(ADDR_NO_REG, $urandom);
      for (int i = 0; i < PHASE_SAMPLES; i++) begin
        if (p == 3 && i == PHASE_SAMPLES / 2) wait_idle();
        random_sample();
      end
    end
    idle_off = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_gains();
    test_proportional();
    test_integral_clamp();
    test_derivative();
    test_restart();
    test_config_clearing();
    test_gain_extremes();
    test_random_phases();
    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
